// File: rtl/core/crf_pkg.sv
`default_nettype none

package crf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CH_W     = 2;
	localparam int LEN_W    = 11;
	localparam int STEP_W   = 17;
	localparam int RAMP_W   = 16;
	localparam int CFG_W    = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [RAMP_W-1:0] RAMP_MAX = {RAMP_W{1'b1}};

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 2'd2;

	localparam logic [CH_W-1:0]   TARGET_RESET    = 2'd0;
	localparam logic [LEN_W-1:0]  FRAME_LEN_RESET = 11'd480;
	localparam logic [STEP_W-1:0] RAMP_STEP_RESET = 17'd137;

	typedef enum logic [1:0] {
		MODE_PASS = 2'd0,
		MODE_COPY = 2'd1,
		MODE_FADE = 2'd2
	} mode_t;

	typedef enum logic {
		ACT_SAMPLE = 1'b0,
		ACT_FORGET = 1'b1
	} action_t;

	typedef struct packed {
		logic                       action;
		logic [CH_W-1:0]            source_channel;
		logic signed [SAMPLE_W-1:0] sample_ch0;
		logic signed [SAMPLE_W-1:0] sample_ch1;
		logic signed [SAMPLE_W-1:0] sample_ch2;
		logic signed [SAMPLE_W-1:0] sample_ch3;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_sample;
		logic [1:0]                 mode;
		logic                       frame_end;
	} out_item_t;

	typedef struct packed {
		logic [CH_W-1:0]   target;
		logic [LEN_W-1:0]  frame_len;
		logic [STEP_W-1:0] ramp_step;
	} cfg_t;

	// operands of the mixer, one per sample
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] old_sample;
		logic signed [SAMPLE_W-1:0] new_sample;
		logic [RAMP_W-1:0]          ramp;
		logic [1:0]                 mode;
		logic                       frame_end;
	} fade_req_t;

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(in_item_t it,
			logic [CH_W-1:0] ch);
		logic signed [SAMPLE_W-1:0] s;
		case (ch)
			2'd0: s = it.sample_ch0;
			2'd1: s = it.sample_ch1;
			2'd2: s = it.sample_ch2;
			default: s = it.sample_ch3;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/crf_ctrl.sv
`default_nettype none

module crf_ctrl #(
	parameter int MAX_FRAME = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  crf_pkg::in_item_t      item,
	input  crf_pkg::cfg_t          cfg,
	output crf_pkg::fade_req_t     req,
	output logic                   has_result
);
	import crf_pkg::*;

	localparam int IDX_W = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
	localparam int CMP_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

	logic [CH_W-1:0]   prev_src_q;
	logic [CH_W-1:0]   frame_src_q;
	mode_t             mode_q;
	logic [IDX_W-1:0]  idx_q;
	logic [RAMP_W-1:0] ramp_q;

	logic [CMP_W-1:0]  len_raw;
	logic [CMP_W-1:0]  len_max;
	logic [CMP_W-1:0]  len_eff;
	logic [CMP_W-1:0]  pos_next;
	logic              first;
	logic              last;
	logic [CH_W-1:0]   src;
	mode_t             mode;
	logic [RAMP_W-1:0] ramp_used;
	logic [RAMP_W+1:0] ramp_sum;
	logic [RAMP_W-1:0] ramp_next;
	logic              forget;

	// effective frame length, zero taken as one, clamped to the frame limit
	assign len_raw = CMP_W'(cfg.frame_len);
	assign len_max = CMP_W'(MAX_FRAME);
	assign len_eff = (len_raw == '0) ? CMP_W'(1) : ((len_raw > len_max) ? len_max : len_raw);

	assign pos_next = CMP_W'(idx_q) + CMP_W'(1);
	assign first    = (idx_q == '0);
	assign last     = (pos_next >= len_eff);
	assign forget   = (action_t'(item.action) == ACT_FORGET);

	assign src = first ? item.source_channel : frame_src_q;

	always_comb begin
		if (!first) begin
			mode = mode_q;
		end else if (src != prev_src_q) begin
			mode = MODE_FADE;
		end else if (src == cfg.target) begin
			mode = MODE_PASS;
		end else begin
			mode = MODE_COPY;
		end
	end

	// saturating q0.16 ramp, restarted on each frame
	assign ramp_used = first ? '0 : ramp_q;
	assign ramp_sum  = {2'b00, ramp_used} + {1'b0, cfg.ramp_step};
	assign ramp_next = (ramp_sum > {2'b00, RAMP_MAX}) ? RAMP_MAX : ramp_sum[RAMP_W-1:0];

	always_comb begin
		req.mode      = mode;
		req.frame_end = last;
		case (mode)
			MODE_PASS: begin
				req.old_sample = pick_sample(item, cfg.target);
				req.new_sample = req.old_sample;
				req.ramp       = '0;
			end
			MODE_COPY: begin
				req.old_sample = pick_sample(item, src);
				req.new_sample = req.old_sample;
				req.ramp       = '0;
			end
			MODE_FADE: begin
				req.old_sample = pick_sample(item, prev_src_q);
				req.new_sample = pick_sample(item, src);
				req.ramp       = ramp_used;
			end
			default: begin
				req.old_sample = pick_sample(item, cfg.target);
				req.new_sample = req.old_sample;
				req.ramp       = '0;
			end
		endcase
	end

	assign has_result = !forget;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_src_q  <= TARGET_RESET;
			frame_src_q <= '0;
			mode_q      <= MODE_PASS;
			idx_q       <= '0;
			ramp_q      <= '0;
		end else if (advance) begin
			if (forget) begin
				prev_src_q <= cfg.target;
			end else begin
				frame_src_q <= src;
				mode_q      <= mode;
				ramp_q      <= ramp_next;
				if (last) begin
					idx_q      <= '0;
					prev_src_q <= src;
				end else begin
					idx_q <= pos_next[IDX_W-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/crf_fade.sv
`default_nettype none

module crf_fade (
	input  crf_pkg::fade_req_t req,
	output crf_pkg::out_item_t res
);
	import crf_pkg::*;

	// (r*new + (1-r)*old + half) >> 16 rewritten as old + ((r*(new-old) + half) >>> 16)
	logic signed [SAMPLE_W:0]     diff;
	logic signed [RAMP_W:0]       ramp_s;
	logic signed [2*SAMPLE_W+1:0] prod;
	logic signed [2*SAMPLE_W+1:0] prod_rnd;
	logic signed [SAMPLE_W+1:0]   delta;
	logic signed [SAMPLE_W+1:0]   mix;

	assign diff     = $signed({req.new_sample[SAMPLE_W-1], req.new_sample})
		- $signed({req.old_sample[SAMPLE_W-1], req.old_sample});
	assign ramp_s   = $signed({1'b0, req.ramp});
	assign prod     = ramp_s * diff;
	assign prod_rnd = prod + $signed((2*SAMPLE_W+2)'(32768));
	assign delta    = $signed(prod_rnd[2*SAMPLE_W+1:16]);
	assign mix      = delta + $signed({{2{req.old_sample[SAMPLE_W-1]}}, req.old_sample});

	assign res.out_sample = mix[SAMPLE_W-1:0];
	assign res.mode       = req.mode;
	assign res.frame_end  = req.frame_end;

endmodule

`default_nettype wire

// File: rtl/core/channel_replace_crossfade.sv
`default_nettype none

// channel      | handshake                    | payload
// -------------+------------------------------+---------------------------------
// sample       | sample_valid / sample_ready  | crf_pkg::in_item_t (one slot)
// result       | result_valid / result_ready  | crf_pkg::out_item_t
// config write | cfg_we                       | cfg_index, cfg_data (no read-back)
//
// one request per clock sustained while result_ready stays high; an accepted request
// is loaded into the input register, then the mix operands register, then the result
// register, which drives result_valid
// a forget request updates the previous source and gives no result
// arst_n clears all control state; config returns to target 0, length 480, step 137
// a stalled result holds the result register; the earlier stages keep filling
// until full, so sample_ready drops only when all three stages hold data

module channel_replace_crossfade #(
	parameter int MAX_FRAME = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output logic                                   sample_ready,
	input  crf_pkg::in_item_t                      sample,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output crf_pkg::out_item_t                     result,
	input  wire logic                              cfg_we,
	input  wire logic [crf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [crf_pkg::CFG_W-1:0]         cfg_data
);
	import crf_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	// stage 1: accepted request
	logic      v_s1;
	in_item_t  item_s1;

	// stage 2: mixer operands
	logic      v_s2;
	fade_req_t req_s2;

	// result register
	logic      res_v_q;
	out_item_t res_q;

	fade_req_t req_c;
	out_item_t res_c;
	logic      has_result;
	logic      out_free;
	logic      take_s2;
	logic      adv_s1;

	// pipeline moves where the next stage is empty or draining
	assign out_free     = !res_v_q || result_ready;
	assign take_s2      = !v_s2 || out_free;
	assign adv_s1       = v_s1 && take_s2;
	assign sample_ready = !v_s1 || take_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target    <= TARGET_RESET;
			cfg_q.frame_len <= FRAME_LEN_RESET;
			cfg_q.ramp_step <= RAMP_STEP_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET:    cfg_q.target    <= cfg_data[CH_W-1:0];
				CFG_FRAME_LEN: cfg_q.frame_len <= cfg_data[LEN_W-1:0];
				CFG_RAMP_STEP: cfg_q.ramp_step <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// frame tracking, mode choice and operand selection
	crf_ctrl #(
		.MAX_FRAME(MAX_FRAME)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (adv_s1),
		.item      (item_s1),
		.cfg       (cfg_q),
		.req       (req_c),
		.has_result(has_result)
	);

	// single multiply mixer
	crf_fade u_fade (
		.req(req_s2),
		.res(res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (sample_ready) begin
				v_s1 <= sample_valid;
			end
			if (take_s2) begin
				v_s2 <= adv_s1 && has_result;
			end
			if (out_free) begin
				res_v_q <= v_s2;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			item_s1 <= sample;
		end
		if (take_s2) begin
			req_s2 <= req_c;
		end
		if (out_free) begin
			res_q <= res_c;
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

	// pass and copy must never reach the mixer with a non-zero weight
	a_plain_no_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (req_s2.mode == MODE_PASS || req_s2.mode == MODE_COPY))
			|-> (req_s2.ramp == '0))
		else $error("pass or copy request carries a fade weight");

	// a held operand stage is not overwritten while the result register stalls
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !out_free) |=> (v_s2 && $stable(req_s2)))
		else $error("mixer operands lost during result stall");

	// back-pressure only when every stage is occupied
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (v_s1 && v_s2 && res_v_q))
		else $error("sample_ready low with a free stage");

endmodule

`default_nettype wire
